>>> hw/rtl/sgdm_pkg.sv
package sgdm_pkg;

   // field and arithmetic widths
   localparam int INDEX_W  = 16;
   localparam int DATA_W   = 32;
   localparam int FACTOR_W = 24;
   localparam int PROD_W   = FACTOR_W + 1 + DATA_W;
   localparam int SUM_W    = PROD_W + 1;

   // index reduction by reciprocal multiply
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int QPROD_W     = INDEX_W + RECIP_W;
   localparam int REM_W       = 26;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // configuration port
   localparam int CSR_IDX_W = 4;
   localparam logic [FACTOR_W-1:0] STEP_SIZE_RESET = 24'd167772;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE       = 4'd0,
      CSR_MOMENTUM_FACTOR = 4'd1,
      CSR_DECAY_FACTOR    = 4'd2,
      CSR_NESTEROV_ENABLE = 4'd3
   } csr_index_type;

   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [INDEX_W-1:0]       element_index;
      logic signed [DATA_W-1:0] param_value;
      logic signed [DATA_W-1:0] gradient;
      logic                     skip_update;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]       index_out;
      logic signed [DATA_W-1:0] updated_value;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] step_size;
      logic [FACTOR_W-1:0] momentum_factor;
      logic [FACTOR_W-1:0] decay_factor;
      logic                nesterov_enable;
   } cfg_type;

   // one element on its way through the block
   typedef struct packed {
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] grad;
      logic                     skip;
      logic                     sat;
   } work_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     flag;
   } sat_type;

   function automatic logic signed [SUM_W-1:0] widen_data(input logic signed [DATA_W-1:0] x);
      return {{(SUM_W-DATA_W){x[DATA_W-1]}}, x};
   endfunction

   function automatic logic signed [SUM_W-1:0] widen_prod(input logic signed [PROD_W-1:0] x);
      return {{(SUM_W-PROD_W){x[PROD_W-1]}}, x};
   endfunction

   // clip a wide sum to 32 bits and flag it
   function automatic sat_type saturate(input logic signed [SUM_W-1:0] x);
      sat_type r;
      logic [SUM_W-DATA_W:0] upper;
      upper = x[SUM_W-1:DATA_W-1];
      if (upper == '0 || upper == '1) begin
         r.value = x[DATA_W-1:0];
         r.flag  = 1'b0;
      end else begin
         r.value = x[SUM_W-1] ? DATA_MIN : DATA_MAX;
         r.flag  = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/sgd_momentum_param_update.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  sgdm_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall  sgdm_pkg::rsp_type
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// one element per cycle while nothing stalls; path: 3 front stages, the queue, 7 back stages.
// an updating element whose velocity slot matches a velocity write by one of the two elements
// just ahead of it waits in the queue until that write has reached the velocity store.
// after reset a clearing sweep zeroes every slot of the velocity store;
// req_stall is high during the sweep, csr writes are taken throughout.
// a stalled result freezes the back pipeline; the 4-entry queue lets the front keep accepting.
module sgd_momentum_param_update #(
   parameter int VELOCITY_DEPTH = 65536,
   parameter int FRAC_BITS      = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sgdm_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sgdm_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sgdm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sgdm_pkg::FACTOR_W-1:0]     csr_data
);

   localparam int SLOT_W = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
   localparam int WORK_W = $bits(sgdm_pkg::work_type);
   localparam int ENTRY_W = WORK_W + SLOT_W;

   sgdm_pkg::cfg_type cfg_ff, cfg_in;

   logic                 clearing;
   logic                 push, pop, q_full, q_empty;
   sgdm_pkg::work_type   push_work, head_work;
   logic [SLOT_W-1:0]    push_slot, head_slot;
   logic [ENTRY_W-1:0]   push_data, head_data;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sgdm_pkg::CSR_STEP_SIZE:       cfg_in.step_size       = csr_data;
            sgdm_pkg::CSR_MOMENTUM_FACTOR: cfg_in.momentum_factor = csr_data;
            sgdm_pkg::CSR_DECAY_FACTOR:    cfg_in.decay_factor    = csr_data;
            sgdm_pkg::CSR_NESTEROV_ENABLE: cfg_in.nesterov_enable = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size       <= sgdm_pkg::STEP_SIZE_RESET;
         cfg_ff.momentum_factor <= '0;
         cfg_ff.decay_factor    <= '0;
         cfg_ff.nesterov_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgdm_front #(
      .VELOCITY_DEPTH (VELOCITY_DEPTH),
      .FRAC_BITS      (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (clearing),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_payload),
      .push      (push),
      .push_work (push_work),
      .push_slot (push_slot),
      .q_full    (q_full)
   );

   assign push_data = {push_work, push_slot};

   sgdm_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head_data)
   );

   assign head_work = head_data[ENTRY_W-1:SLOT_W];
   assign head_slot = head_data[SLOT_W-1:0];

   sgdm_back #(
      .VELOCITY_DEPTH (VELOCITY_DEPTH),
      .FRAC_BITS      (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_work      (head_work),
      .q_slot      (head_slot),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .clearing    (clearing)
   );

endmodule

>>> hw/rtl/sgdm_front.sv
module sgdm_front #(
   parameter int VELOCITY_DEPTH = 65536,
   parameter int FRAC_BITS      = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         hold,
   input  sgdm_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  sgdm_pkg::req_type            in_item,
   output logic                         push,
   output sgdm_pkg::work_type           push_work,
   output logic [((VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1)-1:0] push_slot,
   input  logic                         q_full
);

   localparam int SLOT_W = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
   localparam logic [sgdm_pkg::RECIP_W-1:0] RECIP =
      sgdm_pkg::RECIP_W'((64'd1 << sgdm_pkg::RECIP_SHIFT) / VELOCITY_DEPTH);
   localparam logic [sgdm_pkg::REM_W-1:0] DEPTH_C = sgdm_pkg::REM_W'(VELOCITY_DEPTH);

   logic f_en;
   logic accept;

   logic f1_valid_ff, f2_valid_ff, f3_valid_ff;

   sgdm_pkg::req_type                      f1_item_ff;
   logic signed [sgdm_pkg::PROD_W-1:0]     f1_dprod_ff, f1_dprod_in;
   logic [sgdm_pkg::QPROD_W-1:0]           f1_qprod_ff, f1_qprod_in;

   sgdm_pkg::work_type                     f2_work_ff, f2_work_in;
   logic [sgdm_pkg::REM_W-1:0]             f2_qd_ff, f2_qd_in;

   sgdm_pkg::work_type                     f3_work_ff;
   logic [SLOT_W-1:0]                      f3_slot_ff, f3_slot_in;

   logic signed [sgdm_pkg::PROD_W-1:0]     dshift;
   sgdm_pkg::sat_type                      gsat;
   logic [sgdm_pkg::INDEX_W-1:0]           quot;
   logic [sgdm_pkg::REM_W-1:0]             rem, rem_fix;

   // whole front moves unless the last stage cannot enter the queue
   assign f_en     = !f3_valid_ff || !q_full;
   assign in_stall = hold || !f_en;
   assign accept   = in_valid && !in_stall;

   assign push      = f3_valid_ff && !q_full;
   assign push_work = f3_work_ff;
   assign push_slot = f3_slot_ff;

   // stage 1: decay product and reciprocal product
   assign f1_dprod_in = $signed({1'b0, cfg.decay_factor}) * $signed(in_item.param_value);
   assign f1_qprod_in = in_item.element_index * RECIP;

   // stage 2: decayed gradient, quotient times depth
   assign dshift = f1_dprod_ff >>> FRAC_BITS;
   assign gsat   = sgdm_pkg::saturate(sgdm_pkg::widen_prod(dshift)
                                      + sgdm_pkg::widen_data(f1_item_ff.gradient));
   assign quot   = f1_qprod_ff[sgdm_pkg::RECIP_SHIFT +: sgdm_pkg::INDEX_W];
   assign f2_qd_in = quot * DEPTH_C;

   always_comb begin
      f2_work_in.index = f1_item_ff.element_index;
      f2_work_in.value = f1_item_ff.param_value;
      f2_work_in.grad  = gsat.value;
      f2_work_in.skip  = f1_item_ff.skip_update;
      f2_work_in.sat   = gsat.flag;
   end

   // stage 3: remainder with one correction step
   assign rem        = {{(sgdm_pkg::REM_W-sgdm_pkg::INDEX_W){1'b0}}, f2_work_ff.index} - f2_qd_ff;
   assign rem_fix    = (rem >= DEPTH_C) ? (rem - DEPTH_C) : rem;
   assign f3_slot_in = rem_fix[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (f_en) begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) begin
         f1_item_ff  <= in_item;
         f1_dprod_ff <= f1_dprod_in;
         f1_qprod_ff <= f1_qprod_in;
         f2_work_ff  <= f2_work_in;
         f2_qd_ff    <= f2_qd_in;
         f3_work_ff  <= f2_work_ff;
         f3_slot_ff  <= f3_slot_in;
      end
   end

endmodule

>>> hw/rtl/sgdm_queue.sv
module sgdm_queue #(
   parameter int WIDTH = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0]                entry_ff [sgdm_pkg::QUEUE_DEPTH];
   logic [sgdm_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sgdm_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sgdm_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full  = (count_ff == sgdm_pkg::QCNT_W'(sgdm_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/sgdm_back.sv
module sgdm_back #(
   parameter int VELOCITY_DEPTH = 65536,
   parameter int FRAC_BITS      = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sgdm_pkg::cfg_type    cfg,
   input  logic                 q_empty,
   input  sgdm_pkg::work_type   q_work,
   input  logic [((VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1)-1:0] q_slot,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sgdm_pkg::rsp_type    rsp_payload,
   output logic                 clearing
);

   localparam int SLOT_W = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VELOCITY_DEPTH - 1);

   logic [sgdm_pkg::DATA_W-1:0] vel_mem [VELOCITY_DEPTH];

   logic b_en, mom_on, head_we, hazard, issue, wr_go;

   logic clr_active_ff;
   logic [SLOT_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic rsp_valid_ff;

   sgdm_pkg::work_type s1_work_ff, s2_work_ff, s3_work_ff, s4_work_ff, s5_work_ff, s6_work_ff;
   sgdm_pkg::work_type s3_work_in, s5_work_in;
   logic [SLOT_W-1:0]  s1_slot_ff, s2_slot_ff;
   logic               s1_we_ff, s2_we_ff;

   logic [sgdm_pkg::DATA_W-1:0]          vel_rd_ff;
   logic signed [sgdm_pkg::PROD_W-1:0]   s2_p1_ff, s2_p1_in;
   logic signed [sgdm_pkg::DATA_W-1:0]   s3_vel_ff, s4_vel_ff;
   logic signed [sgdm_pkg::PROD_W-1:0]   s4_p2_ff, s4_p2_in;
   logic signed [sgdm_pkg::DATA_W-1:0]   s5_d_ff, s5_d_in;
   logic signed [sgdm_pkg::PROD_W-1:0]   s6_p3_ff, s6_p3_in;
   sgdm_pkg::rsp_type                    rsp_ff, rsp_in;

   logic signed [sgdm_pkg::PROD_W-1:0]   p1_sh, p2_sh, p3_sh;
   sgdm_pkg::sat_type                    v_sat, n_sat, r_sat;

   // back pipeline moves as one unless the result register is held
   assign b_en     = !rsp_valid_ff || !rsp_stall;
   assign mom_on   = (cfg.momentum_factor != '0);
   assign head_we  = !q_work.skip && mom_on;

   // a velocity write still ahead of its store cycle blocks an updating element from reading the same slot
   assign hazard = (s1_valid_ff && s1_we_ff && (s1_slot_ff == q_slot))
                || (s2_valid_ff && s2_we_ff && (s2_slot_ff == q_slot));
   assign issue  = !q_empty && b_en && !clr_active_ff && !(head_we && hazard);
   assign q_pop  = issue;
   assign wr_go  = s2_valid_ff && s2_we_ff && b_en;

   assign clearing    = clr_active_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // stage 2: momentum times stored velocity
   assign s2_p1_in = $signed({1'b0, cfg.momentum_factor}) * $signed(vel_rd_ff);

   // stage 3: new velocity
   assign p1_sh = s2_p1_ff >>> FRAC_BITS;
   assign v_sat = sgdm_pkg::saturate(sgdm_pkg::widen_prod(p1_sh)
                                     + sgdm_pkg::widen_data(s2_work_ff.grad));
   always_comb begin
      s3_work_in     = s2_work_ff;
      s3_work_in.sat = s2_work_ff.sat | v_sat.flag;
   end

   // stage 4: momentum times new velocity for look-ahead
   assign s4_p2_in = $signed({1'b0, cfg.momentum_factor}) * s3_vel_ff;

   // stage 5: step direction
   assign p2_sh = s4_p2_ff >>> FRAC_BITS;
   assign n_sat = sgdm_pkg::saturate(sgdm_pkg::widen_prod(p2_sh)
                                     + sgdm_pkg::widen_data(s4_work_ff.grad));
   always_comb begin
      s5_work_in = s4_work_ff;
      if (cfg.nesterov_enable) begin
         s5_d_in        = n_sat.value;
         s5_work_in.sat = s4_work_ff.sat | n_sat.flag;
      end else begin
         s5_d_in = s4_vel_ff;
      end
   end

   // stage 6: rate times direction
   assign s6_p3_in = $signed({1'b0, cfg.step_size}) * s5_d_ff;

   // result: subtract the step, skipped elements pass through
   assign p3_sh = s6_p3_ff >>> FRAC_BITS;
   assign r_sat = sgdm_pkg::saturate(sgdm_pkg::widen_data(s6_work_ff.value)
                                     - sgdm_pkg::widen_prod(p3_sh));
   always_comb begin
      rsp_in.index_out = s6_work_ff.index;
      if (s6_work_ff.skip) begin
         rsp_in.updated_value = s6_work_ff.value;
         rsp_in.saturated     = 1'b0;
      end else begin
         rsp_in.updated_value = r_sat.value;
         rsp_in.saturated     = s6_work_ff.sat | r_sat.flag;
      end
   end

   // clearing sweep after reset
   assign clr_cnt_in = clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         if (clr_cnt_ff == LAST_SLOT) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_cnt_ff <= clr_cnt_in;
         end
      end
   end

   // velocity store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         vel_mem[clr_cnt_ff] <= '0;
      end else if (wr_go) begin
         vel_mem[s2_slot_ff] <= v_sat.value;
      end
      if (issue) begin
         vel_rd_ff <= vel_mem[q_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (b_en) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         s1_work_ff <= q_work;
         s1_slot_ff <= q_slot;
         s1_we_ff   <= head_we;
         s2_work_ff <= s1_work_ff;
         s2_slot_ff <= s1_slot_ff;
         s2_we_ff   <= s1_we_ff;
         s2_p1_ff   <= s2_p1_in;
         s3_work_ff <= s3_work_in;
         s3_vel_ff  <= v_sat.value;
         s4_work_ff <= s3_work_ff;
         s4_vel_ff  <= s3_vel_ff;
         s4_p2_ff   <= s4_p2_in;
         s5_work_ff <= s5_work_in;
         s5_d_ff    <= s5_d_in;
         s6_work_ff <= s5_work_ff;
         s6_p3_ff   <= s6_p3_in;
         rsp_ff     <= rsp_in;
      end
   end

endmodule

>>> hw/rtl/sgdm_checker.sv
module sgdm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sgdm_pkg::rsp_type rsp_payload
);

   localparam int OUT_W = 5;

   logic             req_xfer, rsp_xfer;
   logic [OUT_W-1:0] pending_ff, pending_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // elements taken in and not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result is shown right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // the clearing sweep keeps the input closed after reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open before the velocity store is cleared");

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("held result changed");

   // every result belongs to an element taken in
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("result without a pending element");

endmodule

bind sgd_momentum_param_update sgdm_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
